FILE: src/ffac_pkg.sv
// ----------------------------------------------------------------------------
// ffac_pkg: shared types and constants of the FIFO fully associative cache
// Request and response words, operation codes and the line write controls.
// ----------------------------------------------------------------------------
package ffac_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned ModeW = 2;

  localparam logic [ModeW-1:0] MODE_READ  = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd1;
  localparam logic [ModeW-1:0] MODE_PUT   = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] write_data;
  } ffac_req_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] read_data;
    logic             evicted;
    logic [AddrW-1:0] evicted_addr;
    logic [DataW-1:0] evicted_data;
    logic             evicted_dirty;
  } ffac_rsp_t;

  typedef struct packed {
    logic             en;
    logic             dirty;
    logic [DataW-1:0] data;
  } ffac_wr_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] hit_data;
    logic [AddrW-1:0] old_addr;
    logic [DataW-1:0] old_data;
    logic             old_dirty;
  } ffac_look_t;

endpackage

FILE: src/ffac_lines.sv
// ----------------------------------------------------------------------------
// ffac_lines: line storage with a parallel address compare
// Holds address, data and dirty mark of every line plus a valid bit, matches
// the key against all valid lines, and updates in place or allocates.
// ----------------------------------------------------------------------------
module ffac_lines #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ffac_pkg::AddrW-1:0] key_i,
  input  ffac_pkg::ffac_wr_t      wr_i,
  input  logic [IdxW-1:0]         alloc_slot_i,
  input  logic [IdxW-1:0]         old_slot_i,
  output ffac_pkg::ffac_look_t    look_o
);

  logic [ffac_pkg::AddrW-1:0] line_addr_q  [ENTRIES];
  logic [ffac_pkg::DataW-1:0] line_data_q  [ENTRIES];
  logic                       line_dirty_q [ENTRIES];
  logic [ENTRIES-1:0]         valid_q;
  logic [ENTRIES-1:0]         match;
  logic [ffac_pkg::DataW-1:0] hit_data;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_line
    logic upd;
    logic alloc;

    assign match[i] = valid_q[i] && (line_addr_q[i] == key_i);
    assign upd      = wr_i.en && match[i];
    assign alloc    = wr_i.en && !(|match) && (alloc_slot_i == IdxW'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (alloc) begin
        valid_q[i] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (alloc) begin
        line_addr_q[i] <= key_i;
      end
      if (upd || alloc) begin
        line_data_q[i]  <= wr_i.data;
        line_dirty_q[i] <= wr_i.dirty;
      end
    end
  end

  always_comb begin
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_data = hit_data | (line_data_q[i] & {ffac_pkg::DataW{match[i]}});
    end
  end

  assign look_o.hit       = |match;
  assign look_o.hit_data  = hit_data;
  assign look_o.old_addr  = line_addr_q[old_slot_i];
  assign look_o.old_data  = line_data_q[old_slot_i];
  assign look_o.old_dirty = line_dirty_q[old_slot_i];

endmodule

FILE: src/fifo_fully_associative_cache_unit.sv
// ----------------------------------------------------------------------------
// fifo_fully_associative_cache_unit: fully associative cache, FIFO replacement
// Flow: an accepted word is registered in req_q, looked up in the line storage
// combinationally, and its response is registered in rsp_q with valid_o.
// Throughput: one word per cycle; busy_o never rises, the result receiver
// cannot stall. The lookup, line update and ring pointer update happen together.
// Reset clears the valid bits, the oldest pointer and the fill count at once.
// ----------------------------------------------------------------------------
module fifo_fully_associative_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ffac_pkg::ffac_req_t req_i,
  output logic                valid_o,
  output ffac_pkg::ffac_rsp_t rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  ffac_pkg::ffac_req_t  req_q;
  logic                 req_vld_q;
  ffac_pkg::ffac_rsp_t  rsp_q, rsp_d;
  logic                 rsp_vld_q;
  logic [IdxW-1:0]      oldest_q, oldest_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic                 full;
  logic                 is_wr;
  logic [IdxW-1:0]      alloc_slot;
  ffac_pkg::ffac_wr_t   wr;
  ffac_pkg::ffac_look_t look;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  assign full       = (fill_q == CntW'(ENTRIES));
  assign is_wr      = (req_q.mode == ffac_pkg::MODE_WRITE) || (req_q.mode == ffac_pkg::MODE_PUT);
  assign alloc_slot = full ? oldest_q : fill_q[IdxW-1:0];

  assign wr.en    = req_vld_q && is_wr;
  assign wr.dirty = (req_q.mode == ffac_pkg::MODE_WRITE);
  assign wr.data  = req_q.write_data;

  ffac_lines #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW)
  ) u_lines (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (req_q.addr),
    .wr_i         (wr),
    .alloc_slot_i (alloc_slot),
    .old_slot_i   (oldest_q),
    .look_o       (look)
  );

  always_comb begin
    oldest_d = oldest_q;
    fill_d   = fill_q;
    rsp_d    = '0;
    rsp_d.hit = look.hit;
    if (is_wr) begin
      if (!look.hit) begin
        if (full) begin
          rsp_d.evicted       = 1'b1;
          rsp_d.evicted_addr  = look.old_addr;
          rsp_d.evicted_data  = look.old_data;
          rsp_d.evicted_dirty = look.old_dirty;
          oldest_d = (oldest_q == IdxW'(ENTRIES - 1)) ? '0 : oldest_q + IdxW'(1);
        end else begin
          fill_d = fill_q + CntW'(1);
        end
      end
    end else if (look.hit) begin
      rsp_d.read_data = look.hit_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      fill_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= req_vld_q;
      if (req_vld_q) begin
        oldest_q <= oldest_d;
        fill_q   <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = rsp_vld_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: dv/ffac_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffac_checker: response checker for the FIFO fully associative cache
// Watches the request and response channels of the cache. It keeps its own
// copy of the lines and the ring pointer, and predicts the response of every
// accepted word. Each response is compared field by field with the oldest
// prediction. It reports failures and progress counts to the testbench top.
// ----------------------------------------------------------------------------
module ffac_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  ffac_pkg::ffac_req_t req_i,
  input  logic                valid_i,
  input  ffac_pkg::ffac_rsp_t rsp_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         hits_o,
  output int unsigned         evictions_o
);

  localparam int unsigned SlotW = $clog2(ENTRIES);
  localparam int unsigned FillW = SlotW + 1;

  logic [ffac_pkg::AddrW-1:0] line_addr [ENTRIES];
  logic [ffac_pkg::DataW-1:0] line_data [ENTRIES];
  logic                       line_dirty [ENTRIES];
  logic [SlotW-1:0]           oldest_slot;
  logic [FillW-1:0]           fill_count;

  ffac_pkg::ffac_rsp_t expected_rsp_q [$];
  int unsigned         fail_cnt;
  int unsigned         checked_cnt;
  int unsigned         hit_cnt;
  int unsigned         evict_cnt;

  function automatic ffac_pkg::ffac_rsp_t cache_predict(ffac_pkg::ffac_req_t w);
    ffac_pkg::ffac_rsp_t rsp;
    int                  slot;
    logic [SlotW-1:0]    age;
    logic [SlotW-1:0]    target;
    logic                dirty;
    rsp  = '0;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      age = SlotW'(i) - oldest_slot;
      if (slot < 0 && FillW'(age) < fill_count && line_addr[i] == w.addr) begin
        slot = i;
      end
    end
    rsp.hit = (slot >= 0);
    if (w.mode == ffac_pkg::MODE_WRITE || w.mode == ffac_pkg::MODE_PUT) begin
      dirty = (w.mode == ffac_pkg::MODE_WRITE);
      if (rsp.hit) begin
        line_data[slot]  = w.write_data;
        line_dirty[slot] = dirty;
      end else begin
        if (fill_count < FillW'(ENTRIES)) begin
          target     = oldest_slot + fill_count[SlotW-1:0];
          fill_count = fill_count + FillW'(1);
        end else begin
          target            = oldest_slot;
          rsp.evicted       = 1'b1;
          rsp.evicted_addr  = line_addr[target];
          rsp.evicted_data  = line_data[target];
          rsp.evicted_dirty = line_dirty[target];
          oldest_slot       = oldest_slot + SlotW'(1);
        end
        line_addr[target]  = w.addr;
        line_data[target]  = w.write_data;
        line_dirty[target] = dirty;
      end
    end else if (rsp.hit) begin
      rsp.read_data = line_data[slot];
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ffac_pkg::ffac_rsp_t exp_rsp;
    if (!rst_ni) begin
      expected_rsp_q.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        line_addr[i]  = '0;
        line_data[i]  = '0;
        line_dirty[i] = 1'b0;
      end
      oldest_slot  = '0;
      fill_count   = '0;
      fail_cnt     = 0;
      checked_cnt  = 0;
      hit_cnt      = 0;
      evict_cnt    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      hits_o       <= 0;
      evictions_o  <= 0;
    end else begin
      if (valid_i !== 1'b0) begin
        if (valid_i !== 1'b1 || expected_rsp_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: unexpected response word, valid=%b rsp=%h", $realtime, valid_i,
                     rsp_i);
          end
          fail_cnt++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          checked_cnt++;
          if (rsp_i.hit !== exp_rsp.hit || rsp_i.read_data !== exp_rsp.read_data ||
              rsp_i.evicted !== exp_rsp.evicted ||
              rsp_i.evicted_addr !== exp_rsp.evicted_addr ||
              rsp_i.evicted_data !== exp_rsp.evicted_data ||
              rsp_i.evicted_dirty !== exp_rsp.evicted_dirty) begin
            if (fail_cnt < 10) begin
              $display("%0t: mismatch exp hit=%b rd=%h ev=%b ea=%h ed=%h dirty=%b", $realtime,
                       exp_rsp.hit, exp_rsp.read_data, exp_rsp.evicted,
                       exp_rsp.evicted_addr, exp_rsp.evicted_data, exp_rsp.evicted_dirty);
              $display("%0t:          got hit=%b rd=%h ev=%b ea=%h ed=%h dirty=%b", $realtime,
                       rsp_i.hit, rsp_i.read_data, rsp_i.evicted,
                       rsp_i.evicted_addr, rsp_i.evicted_data, rsp_i.evicted_dirty);
            end
            fail_cnt++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        exp_rsp = cache_predict(req_i);
        if (exp_rsp.hit) hit_cnt++;
        if (exp_rsp.evicted) evict_cnt++;
        expected_rsp_q.push_back(exp_rsp);
      end
      fail_count_o <= fail_cnt;
      pending_o    <= expected_rsp_q.size();
      checked_o    <= checked_cnt;
      hits_o       <= hit_cnt;
      evictions_o  <= evict_cnt;
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the FIFO fully associative cache unit
// Sends a short directed sequence of reads, writes and puts that fills the
// cache and forces evictions, then random words over small address pools in four
// phases, two of them with sender gaps. The checker predicts every response.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ENTRIES = 16;
  localparam logic [ffac_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned PhaseWords = 300;
  localparam int unsigned PoolMax = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  ffac_pkg::ffac_req_t req_i;
  logic                valid_o;
  ffac_pkg::ffac_rsp_t rsp_o;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         checked;
  int unsigned         hits;
  int unsigned         evictions;
  int unsigned         words_sent;

  logic [ffac_pkg::AddrW-1:0] addr_pool [PoolMax];
  int unsigned                idle_pct [4] = '{0, 55, 0, 7};
  int unsigned                pool_size [4] = '{12, 20, 28, 40};
  ffac_pkg::ffac_req_t        directed_q [$];

  fifo_fully_associative_cache_unit #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  ffac_checker #(
    .ENTRIES(ENTRIES)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .valid_i     (valid_o),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .hits_o      (hits),
    .evictions_o (evictions)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic ffac_pkg::ffac_req_t make_word(logic [ffac_pkg::ModeW-1:0] mode,
                                                    logic [ffac_pkg::AddrW-1:0] addr,
                                                    logic [ffac_pkg::DataW-1:0] data);
    ffac_pkg::ffac_req_t w;
    w.mode       = mode;
    w.addr       = addr;
    w.write_data = data;
    return w;
  endfunction

  function automatic ffac_pkg::ffac_req_t random_word(int unsigned n_pool);
    ffac_pkg::ffac_req_t w;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 35) w.mode = ffac_pkg::MODE_READ;
    else if (pick < 65) w.mode = ffac_pkg::MODE_WRITE;
    else if (pick < 94) w.mode = ffac_pkg::MODE_PUT;
    else w.mode = MODE_UNUSED;
    if ($urandom_range(99) < 88) w.addr = addr_pool[$urandom_range(n_pool - 1)];
    else w.addr = $urandom;
    w.write_data = $urandom;
    return w;
  endfunction

  task automatic send_word(ffac_pkg::ffac_req_t w, int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      req_i   <= make_word(MODE_UNUSED, $urandom, $urandom);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    words_sent++;
  endtask

  initial begin
    int unsigned waited;
    start_i    = 1'b0;
    req_i      = '0;
    rst_ni     = 1'b0;
    words_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_q.push_back(make_word(ffac_pkg::MODE_READ, '0, '1));
    directed_q.push_back(make_word(MODE_UNUSED, '0, '1));
    directed_q.push_back(make_word(ffac_pkg::MODE_WRITE, '0, '1));
    directed_q.push_back(make_word(ffac_pkg::MODE_READ, '0, '0));
    directed_q.push_back(make_word(MODE_UNUSED, '0, '0));
    directed_q.push_back(make_word(ffac_pkg::MODE_PUT, '1, '0));
    directed_q.push_back(make_word(ffac_pkg::MODE_WRITE, '1, 32'h5a5a_a5a5));
    directed_q.push_back(make_word(ffac_pkg::MODE_PUT, '0, 32'h1234_5678));
    for (int i = 1; i <= 14; i++) begin
      directed_q.push_back(make_word((i % 2) ? ffac_pkg::MODE_WRITE : ffac_pkg::MODE_PUT,
                                     32'h0100_0000 * i + i, $urandom));
    end
    directed_q.push_back(make_word(ffac_pkg::MODE_WRITE, 32'h8000_0001, $urandom));
    directed_q.push_back(make_word(ffac_pkg::MODE_PUT, 32'h7fff_fffe, $urandom));
    directed_q.push_back(make_word(ffac_pkg::MODE_READ, '0, '1));
    foreach (directed_q[i]) send_word(directed_q[i], 0);

    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < PoolMax; i++) addr_pool[i] = $urandom;
      for (int n = 0; n < PhaseWords; n++) begin
        send_word(random_word(pool_size[phase]), idle_pct[phase]);
      end
    end
    start_i <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);

    $display("Sent %0d words in four gap phases; checked %0d responses.", words_sent, checked);
    $display("Responses covered %0d hits and %0d evictions.", hits, evictions);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: fifo_fully_associative_cache_unit.f
src/ffac_pkg.sv
src/ffac_lines.sv
src/fifo_fully_associative_cache_unit.sv
dv/ffac_checker.sv
dv/tb_top.sv
